// ===== design/yri_pkg.sv =====
package yri_pkg;

  // Field widths
  localparam int GZ_W    = 16;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 21;
  localparam int BIAS_W  = 20;
  localparam int ANGLE_W = 48;
  localparam int COUNT_W = 32;
  localparam int K_W     = 21;               // signed multiplier A operand
  localparam int PROD_W  = K_W + GZ_W;       // 37-bit signed product
  localparam int DT_W    = 8;                // holds up to MAX_DT_MS

  // Interval limits (ms)
  localparam logic [DT_W-1:0] FIRST_DT_MS = 8'd10;
  localparam logic [DT_W-1:0] MAX_DT_MS   = 8'd50;

  // Clip threshold on |gz_raw|
  localparam logic signed [GZ_W-1:0] CLIP_HI = 16'sd31784;
  localparam logic signed [GZ_W-1:0] CLIP_LO = -16'sd31784;

  // Input commands
  localparam logic [1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [1:0] CMD_YAW_CLR  = 2'd1;
  localparam logic [1:0] CMD_CLIP_CLR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RANGE   = 2'd0;
  localparam logic [1:0] REG_BIAS    = 2'd1;
  localparam logic [1:0] REG_BVALID  = 2'd2;
  localparam logic [1:0] REG_PRESENT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RATE,
    ST_STEP,
    ST_ACC,
    ST_POST
  } state_t;

  // Scale factor per full-scale range, Q16 of 1/256 deg/s per LSB
  function automatic logic [K_W-1:0] scale_k(input logic [1:0] range_sel);
    logic [K_W-1:0] k;
    case (range_sel)
      2'd0:    k = 21'd128075;
      2'd1:    k = 21'd256150;
      2'd2:    k = 21'd511500;
      default: k = 21'd1023001;
    endcase
    return k;
  endfunction

endpackage

// ===== design/yaw_rate_integrator_unit.sv =====
// Channel   Direction  Handshake                    Payload
// --------  ---------  ---------------------------  ----------------------------------------
// sample    in         sample_valid / sample_stall  command, gz_raw, time_ms
// result    out        result_valid / result_stall  yaw_rate, yaw_angle, clipped, clip_count,
//                                                   angle_valid
// config    in         write_enable                 write_index, write_data
//
// A sample request (command 0) passes through ST_SCALE, ST_RATE, ST_STEP, ST_ACC and ST_POST
// when integrating, ST_SCALE, ST_RATE and ST_POST when not: one shared 21x16 signed multiplier
// forms first gz*K, then, when integrating, rate*dt, each product registered before its add/saturate step.
// Commands 1, 2 and 3 go straight to ST_POST. A result is loaded on leaving ST_POST, which waits while
// the output register holds a stalled result; the next request is taken in ST_IDLE after the load.
// Only one request is in flight; sample_stall is high from accept until its result
// is loaded into the output register.
// A result held by result_stall blocks loading of the next result, not acceptance.
// rst is synchronous: state, config and control clear; payload registers are free.
module yaw_rate_integrator_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            write_enable,
  input  logic [1:0]                      write_index,
  input  logic [yri_pkg::BIAS_W-1:0]      write_data,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [1:0]                      command,
  input  logic signed [yri_pkg::GZ_W-1:0] gz_raw,
  input  logic [yri_pkg::TIME_W-1:0]      time_ms,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [yri_pkg::RATE_W-1:0]  yaw_rate,
  output logic signed [yri_pkg::ANGLE_W-1:0] yaw_angle,
  output logic                            clipped,
  output logic [yri_pkg::COUNT_W-1:0]     clip_count,
  output logic                            angle_valid
);
  import yri_pkg::*;

  // Configuration registers
  logic [1:0]               gyro_range;
  logic signed [BIAS_W-1:0] rate_bias;
  logic                     bias_valid;
  logic                     sensor_present;

  // Block state
  logic signed [ANGLE_W-1:0] yaw_acc;
  logic [TIME_W-1:0]         last_tick;
  logic signed [RATE_W-1:0]  rate_reg;
  logic                      clip_flag;
  logic [COUNT_W-1:0]        clip_total;
  logic                      integrated_flag;

  // Latched request and working registers
  logic signed [GZ_W-1:0] gz_hold;
  logic [TIME_W-1:0]      time_hold;
  logic [DT_W-1:0]        dt;
  logic signed [PROD_W-1:0] prod;

  state_t state, state_next;

  logic accept;
  logic out_free;
  logic mul_sel_dt;   // 0: gz*K, 1: rate*dt
  logic integrate;

  assign accept    = sample_valid && !sample_stall;
  assign out_free  = !result_valid || !result_stall;
  assign integrate = sensor_present && bias_valid;

  // Shared multiplier
  logic [K_W-1:0]           k_sel;
  logic signed [K_W-1:0]    mul_a;
  logic signed [GZ_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign k_sel = scale_k(gyro_range);
  assign mul_a = mul_sel_dt ? rate_reg : $signed({1'b0, k_sel[K_W-2:0]});
  assign mul_b = mul_sel_dt ? $signed({{(GZ_W-DT_W){1'b0}}, dt}) : gz_hold;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Rate: floor(prod / 2^16) minus bias (when bias_valid), saturated to RATE_W
  logic signed [RATE_W:0]   rate_wide;
  logic signed [RATE_W-1:0] rate_sat;
  logic signed [RATE_W:0]   bias_ext;

  assign bias_ext  = bias_valid ? $signed({{(RATE_W+1-BIAS_W){rate_bias[BIAS_W-1]}}, rate_bias})
                                : '0;
  assign rate_wide = $signed({prod[PROD_W-1], prod[PROD_W-1:16]}) - bias_ext;

  always_comb begin
    if (rate_wide[RATE_W] != rate_wide[RATE_W-1]) begin
      rate_sat = rate_wide[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end else begin
      rate_sat = rate_wide[RATE_W-1:0];
    end
  end

  // Clip detect on the held raw sample
  logic clip_now;
  assign clip_now = (gz_hold >= CLIP_HI) || (gz_hold <= CLIP_LO);

  // Interval: default without a reference, then clamp to 1..MAX_DT_MS
  logic [TIME_W-1:0] diff;
  logic [DT_W-1:0]   dt_next;

  assign diff = time_hold - last_tick;

  always_comb begin
    if (last_tick == '0) begin
      dt_next = FIRST_DT_MS;
    end else if (diff == '0) begin
      dt_next = DT_W'(1);
    end else if (diff > TIME_W'(MAX_DT_MS)) begin
      dt_next = MAX_DT_MS;
    end else begin
      dt_next = diff[DT_W-1:0];
    end
  end

  // Angle accumulate with saturation
  logic signed [ANGLE_W:0]   acc_sum;
  logic signed [ANGLE_W-1:0] acc_sat;

  assign acc_sum = $signed({yaw_acc[ANGLE_W-1], yaw_acc})
                 + $signed({{(ANGLE_W+1-PROD_W){prod[PROD_W-1]}}, prod});

  always_comb begin
    if (acc_sum[ANGLE_W] != acc_sum[ANGLE_W-1]) begin
      acc_sat = acc_sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ANGLE_W-1:0];
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_SAMPLE) ? ST_SCALE : ST_POST;
        end
      end
      ST_SCALE: state_next = ST_RATE;
      ST_RATE:  state_next = integrate ? ST_STEP : ST_POST;
      ST_STEP:  state_next = ST_ACC;
      ST_ACC:   state_next = ST_POST;
      ST_POST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    sample_stall = 1'b1;
    mul_sel_dt   = 1'b0;
    case (state)
      ST_IDLE: sample_stall = 1'b0;
      ST_STEP: mul_sel_dt   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_range     <= 2'd3;
      rate_bias      <= '0;
      bias_valid     <= 1'b0;
      sensor_present <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        REG_RANGE:   gyro_range     <= write_data[1:0];
        REG_BIAS:    rate_bias      <= write_data;
        REG_BVALID:  bias_valid     <= write_data[0];
        REG_PRESENT: sensor_present <= write_data[0];
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      gz_hold   <= gz_raw;
      time_hold <= time_ms;
    end
    if (state == ST_SCALE || state == ST_STEP) begin
      prod <= mul_p;
    end
    if (state == ST_RATE) begin
      dt <= dt_next;
    end
  end

  // Block state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_acc         <= '0;
      last_tick       <= '0;
      rate_reg        <= '0;
      clip_flag       <= 1'b0;
      clip_total      <= '0;
      integrated_flag <= 1'b0;
    end else begin
      if (accept && command == CMD_YAW_CLR) begin
        yaw_acc   <= '0;
        last_tick <= '0;
      end
      if (accept && command == CMD_CLIP_CLR) begin
        clip_total <= '0;
      end
      if (state == ST_RATE) begin
        rate_reg  <= rate_sat;
        clip_flag <= clip_now;
        if (clip_now && clip_total != '1) begin
          clip_total <= clip_total + 1'b1;
        end
        if (integrate) begin
          last_tick <= time_hold;
        end
      end
      if (state == ST_ACC) begin
        yaw_acc         <= acc_sat;
        integrated_flag <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_POST && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST && out_free) begin
      yaw_rate    <= rate_reg;
      yaw_angle   <= yaw_acc;
      clipped     <= clip_flag;
      clip_count  <= clip_total;
      angle_valid <= integrated_flag;
    end
  end

  // Checks
  a_sample_enters_scale: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_SAMPLE |=> state == ST_SCALE)
    else $error("sample request did not start the multiply");

  a_clip_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(accept && command == CMD_CLIP_CLR) |=> clip_total >= $past(clip_total))
    else $error("clip count decreased without a clear");

  a_integrated_sticky: assert property (@(posedge clk) disable iff (rst)
    integrated_flag |=> integrated_flag)
    else $error("integration flag dropped");

  a_yaw_only_in_acc: assert property (@(posedge clk) disable iff (rst)
    state != ST_ACC && !(accept && command == CMD_YAW_CLR) |=> $stable(yaw_acc))
    else $error("yaw accumulator changed outside an update");

  a_dt_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> dt != '0 && dt <= MAX_DT_MS)
    else $error("interval out of range at rate*dt multiply");

endmodule
